/* rtl/scalar_kalman_localizer_unit_macros.svh */
// Assertion macros shared by the scalar Kalman localizer RTL
`ifndef SCALAR_KALMAN_LOCALIZER_UNIT_MACROS_SVH
`define SCALAR_KALMAN_LOCALIZER_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define SKL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SKL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/skl_pkg.sv */
// Package: types and constants of the scalar Kalman localizer
package skl_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned ACC_W  = 32;
    localparam int unsigned COV_W  = 64;
    localparam int unsigned MULT_W = 24;
    localparam int unsigned GAIN_W = 33;

    localparam logic [1:0] OP_MOVE    = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_RELOAD  = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] CFG_INIT_POS = 2'd0;
    localparam logic [1:0] CFG_INIT_ACC = 2'd1;
    localparam logic [1:0] CFG_MULT     = 2'd2;

    localparam logic [COV_W-1:0] COV_RESET = 64'd1073741824;
    localparam logic [ACC_W-1:0] ACC_RESET = 32'd65536;
    localparam logic [MULT_W-1:0] MULT_RESET = 24'd6554;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_MV0, S_MV1, S_MV2,
        S_MS0, S_MS1, S_MS2, S_MS3, S_MS4, S_MS5, S_MS6,
        S_RL0, S_RL1, S_SQ0, S_SQ1, S_DONE
    } t_state;

endpackage

/* rtl/skl_mul.sv */
// Shared 32x32 unsigned multiplier with registered product
module skl_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

/* rtl/skl_div.sv */
// Radix-2 restoring divider: floor(num * 2^32 / den) for num < den
module skl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic [31:0] r_q, n_q;
    logic        r_done, n_done;
    logic [63:0] sh;
    logic        take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        sh     = {r_rem[62:0], 1'b0};
        take   = r_rem[63] || (sh >= r_den);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = i_num;
            n_den  = i_den;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = take ? sh - r_den : sh;
            n_q   = {r_q[30:0], take};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `include "scalar_kalman_localizer_unit_macros.svh"
    `SKL_ASSERT_IMP(a_div_done_idle, r_done, !r_busy, "divider done while busy")
    `SKL_ASSERT_NXT(a_div_start_busy, i_start, r_busy, "divider did not start")
    `SKL_ASSERT_NXT(a_div_finish, r_busy && r_cnt == 5'd0 && !i_start, r_done,
        "divider missed done")
endmodule

/* rtl/skl_sqrt.sv */
// Bit-serial integer square root of a 64-bit word, two radicand bits a cycle
module skl_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x;
    logic [35:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [35:0] sh;
    logic [35:0] trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        sh     = {r_rem[33:0], r_x[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_x    = i_x;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_x = {r_x[61:0], 2'b00};
            if (sh >= trial) begin
                n_rem  = sh - trial;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = sh;
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* rtl/scalar_kalman_localizer_unit.sv */
// Top level: sequencer and state of the scalar Kalman localizer
// Usage:
//   Input channel i_in_valid / o_in_stall carries opcode, value and
//   meas_accuracy; a word is taken when valid is high and stall is low.
//   Output channel o_out_valid / i_out_stall carries position and accuracy
//   estimates; one result word per input word, in order.
//   Config port i_cfg_we / i_cfg_idx / i_cfg_data writes the initial position,
//   initial accuracy and move multiplier; write only while idle.
// Datapath:
//   All multiplication runs through one 32x32 multiplier; division uses a
//   radix-2 divider and square root a 2-bit-per-cycle square root.
//   One word in flight at a time.
// Reset: synchronous active low; position 0, covariance 0.25, registers to
//   their defaults, output empty.
// Stall: a finished result waits in the output register; the block takes the
//   next word meanwhile and holds its own result until the register frees.
module scalar_kalman_localizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic signed [31:0] i_value,
    input  logic [31:0] i_meas_accuracy,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_position_estimate,
    output logic [31:0] o_accuracy_estimate,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import skl_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_init_pos, r_init_acc;
    logic [23:0] r_mult;
    logic [31:0] r_pos, n_pos;
    logic [63:0] r_cov, n_cov;
    logic [31:0] r_val, n_val;
    logic [31:0] r_macc, n_macc;
    logic [32:0] r_gain, n_gain;
    logic [63:0] r_tmp, n_tmp;
    logic [32:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [31:0] r_root, n_root;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_opos, n_opos;
    logic [31:0] r_oacc, n_oacc;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    logic [31:0] vmag;
    logic [31:0] macc_sat;
    logic [32:0] psum;
    logic [64:0] csum;
    logic [32:0] innov;
    logic [33:0] step;
    logic [33:0] pnew;
    logic [32:0] fac;

    skl_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    skl_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_cov), .i_den(n_tmp), .o_done(div_done), .o_quot(div_q)
    );

    skl_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_x(r_cov), .o_done(sq_done), .o_root(sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_init_pos <= '0;
            r_init_acc <= ACC_RESET;
            r_mult     <= MULT_RESET;
            r_pos      <= '0;
            r_cov      <= COV_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_cov    <= n_cov;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INIT_POS: r_init_pos <= i_cfg_data;
                    CFG_INIT_ACC: r_init_acc <= i_cfg_data;
                    CFG_MULT:     r_mult     <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        r_val  <= n_val;
        r_macc <= n_macc;
        r_gain <= n_gain;
        r_tmp  <= n_tmp;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_root <= n_root;
        r_opos <= n_opos;
        r_oacc <= n_oacc;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cov     = r_cov;
        n_val     = r_val;
        n_macc    = r_macc;
        n_gain    = r_gain;
        n_tmp     = r_tmp;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_root    = r_root;
        n_ovalid  = r_ovalid;
        n_opos    = r_opos;
        n_oacc    = r_oacc;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        sq_start  = 1'b0;

        vmag     = r_val[31] ? (~r_val + 32'd1) : r_val;
        macc_sat = (prod[63:56] != 8'd0 || prod[55:48] != 8'd0) ? '1 : prod[47:16];
        psum     = {r_pos[31], r_pos} + {r_val[31], r_val};
        csum     = {1'b0, r_cov} + {3'b000, prod[63:2]};
        innov    = {r_val[31], r_val} - {r_pos[31], r_pos};
        fac      = GAIN_ONE - r_gain;
        if (r_gain[32]) begin
            step = {1'b0, r_mag};
        end else begin
            step = {2'b00, prod[63:32]} + (r_mag[32] ? {2'b00, r_gain[31:0]} : 34'd0);
        end
        pnew = r_neg ? ({{2{r_pos[31]}}, r_pos} - step) : ({{2{r_pos[31]}}, r_pos} + step);

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val  = i_value;
                    n_macc = i_meas_accuracy;
                    unique case (i_opcode)
                        OP_MOVE:    n_state = S_MV0;
                        OP_MEASURE: n_state = S_MS0;
                        OP_RELOAD:  n_state = S_RL0;
                        default:    n_state = S_SQ0;
                    endcase
                end
            end
            S_MV0: begin
                mul_a   = vmag;
                mul_b   = {8'd0, r_mult};
                n_state = S_MV1;
            end
            S_MV1: begin
                mul_a = macc_sat;
                mul_b = macc_sat;
                if (psum[32] != psum[31]) begin
                    n_pos = psum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_pos = psum[31:0];
                end
                n_state = S_MV2;
            end
            S_MV2: begin
                n_cov   = csum[64] ? '1 : csum[63:0];
                n_state = S_SQ0;
            end
            S_MS0: begin
                mul_a   = r_macc;
                mul_b   = r_macc;
                n_state = S_MS1;
            end
            S_MS1: begin
                n_tmp = csum[64] ? '1 : csum[63:0];
                if (csum == 65'd0) begin
                    n_state = S_SQ0;
                end else if (r_cov >= n_tmp) begin
                    n_gain  = GAIN_ONE;
                    n_state = S_MS3;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_MS2;
                end
            end
            S_MS2: begin
                if (div_done) begin
                    n_gain  = {1'b0, div_q};
                    n_state = S_MS3;
                end
            end
            S_MS3: begin
                n_neg   = innov[32];
                n_mag   = innov[32] ? (~innov + 33'd1) : innov;
                mul_a   = innov[32] ? (~innov[31:0] + 32'd1) : innov[31:0];
                mul_b   = r_gain[31:0];
                n_state = S_MS4;
            end
            S_MS4: begin
                if (pnew[33:31] == 3'b000 || pnew[33:31] == 3'b111) begin
                    n_pos = pnew[31:0];
                end else begin
                    n_pos = pnew[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                mul_a   = r_cov[63:32];
                mul_b   = fac[31:0];
                n_state = S_MS5;
            end
            S_MS5: begin
                n_tmp   = prod;
                mul_a   = r_cov[31:0];
                mul_b   = fac[31:0];
                n_state = S_MS6;
            end
            S_MS6: begin
                if (!fac[32]) begin
                    n_cov = r_tmp + {32'd0, prod[63:32]};
                end
                n_state = S_SQ0;
            end
            S_RL0: begin
                mul_a   = r_init_acc;
                mul_b   = r_init_acc;
                n_pos   = r_init_pos;
                n_state = S_RL1;
            end
            S_RL1: begin
                n_cov   = {2'b00, prod[63:2]};
                n_state = S_SQ0;
            end
            S_SQ0: begin
                sq_start = 1'b1;
                n_state  = S_SQ1;
            end
            S_SQ1: begin
                if (sq_done) begin
                    n_root  = sq_root;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_opos   = r_pos;
                    n_oacc   = r_root[31] ? '1 : {r_root[30:0], 1'b0};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_ovalid;
    assign o_position_estimate = r_opos;
    assign o_accuracy_estimate = r_oacc;

    `include "scalar_kalman_localizer_unit_macros.svh"
    `SKL_ASSERT_NXT(a_accept_busy, i_in_valid && !o_in_stall, r_state != S_IDLE,
        "accepted word did not start work")
    `SKL_ASSERT_NXT(a_result_loaded, r_state == S_DONE && !(r_ovalid && i_out_stall),
        r_ovalid && r_state == S_IDLE, "result not loaded")
    `SKL_ASSERT_IMP(a_gain_range, r_state == S_MS4 && r_gain[32], r_gain[31:0] == 32'd0,
        "gain above one")
endmodule

/* dv/tb_scalar_kalman_localizer_unit.sv */
// Self-checking testbench of the scalar Kalman localizer: directed table and corner sequences, then random words
`timescale 1ns / 100ps
`default_nettype none

module tb_scalar_kalman_localizer_unit;
    import skl_pkg::*;

    localparam int N_RANDOM    = 2000;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] val;
        logic [31:0] macc;
        bit          fixed;
        logic [31:0] pos_exp;
        logic [31:0] acc_exp;
    } t_row;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] acc;
    } t_estimate;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = '0;
    logic signed [31:0] i_value = '0;
    logic [31:0] i_meas_accuracy = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [31:0] o_position_estimate;
    logic [31:0] o_accuracy_estimate;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    scalar_kalman_localizer_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [63:0] est_pos;
    logic [63:0] est_cov;
    logic [31:0] cfg_pos, cfg_acc;
    logic [23:0] cfg_mult;

    t_estimate pending_q[$];
    int  n_errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  long_hold = 1'b0;
    int  hold_cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [63:0] cov_of_acc(input logic [31:0] a);
        return ({32'd0, a} * {32'd0, a}) >> 2;
    endfunction

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_pos(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] root_of(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    function automatic t_estimate estimate_step(input logic [1:0] op, input logic [31:0] v,
                                                input logic [31:0] macc);
        logic signed [63:0] d, innov;
        logic [63:0] mag, den, acc64;
        logic [127:0] wide;
        logic [32:0] gain;
        logic [63:0] step;
        logic [64:0] acc2;
        t_estimate e;
        d = {{32{v[31]}}, v};
        if (op == OP_MOVE) begin
            mag = d < 0 ? -d : d;
            acc64 = (mag * {40'd0, cfg_mult}) >> 16;
            if (acc64 > 64'hFFFF_FFFF) acc64 = 64'hFFFF_FFFF;
            est_pos = clamp_pos(est_pos + d);
            est_cov = add_sat64(est_cov, cov_of_acc(acc64[31:0]));
        end else if (op == OP_MEASURE) begin
            den = add_sat64(est_cov, cov_of_acc(macc));
            if (den != 0) begin
                if (est_cov >= den) gain = GAIN_ONE;
                else begin
                    wide = {est_cov, 32'd0};
                    gain = 33'(wide / {64'd0, den});
                end
                innov = d - est_pos;
                mag = innov < 0 ? -innov : innov;
                step = 64'(({64'd0, mag} * {95'd0, gain}) >> 32);
                est_pos = clamp_pos(innov < 0 ? est_pos - $signed(step)
                                              : est_pos + $signed(step));
                wide = {64'd0, est_cov} * {95'd0, GAIN_ONE - gain};
                est_cov = wide[95:32];
            end
        end else if (op == OP_RELOAD) begin
            est_pos = {{32{cfg_pos[31]}}, cfg_pos};
            est_cov = cov_of_acc(cfg_acc);
        end
        acc2 = {32'd0, root_of(est_cov), 1'b0};
        e.pos = est_pos[31:0];
        e.acc = acc2 > 65'hFFFF_FFFF ? 32'hFFFF_FFFF : acc2[31:0];
        return e;
    endfunction

    task automatic idle_burst(input int pct);
        if (!quiet && $urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_word(input logic [1:0] op, input logic [31:0] v, input logic [31:0] m);
        t_estimate e;
        idle_burst(15);
        i_cfg_we        <= 1'b0;
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_value         <= v;
        i_meas_accuracy <= m;
        do @(posedge i_clk); while (o_in_stall);
        e = estimate_step(op, v, m);
        pending_q.push_back(e);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        if (idx == CFG_INIT_POS) cfg_pos = d;
        else if (idx == CFG_INIT_ACC) cfg_acc = d;
        else cfg_mult = d[23:0];
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (long_hold) begin
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!quiet && $urandom_range(99) < 10) begin
            i_out_stall <= 1'b1;
            hold_cycles <= $urandom_range(15, 1);
        end else begin
            i_out_stall <= 1'b0;
        end
        if (hold_cycles == 1 && !long_hold) i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", o_position_estimate, 32'd0);
            end else begin
                e = pending_q.pop_front();
                if (o_position_estimate !== e.pos) report("position", o_position_estimate, e.pos);
                if (o_accuracy_estimate !== e.acc) report("accuracy", o_accuracy_estimate, e.acc);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAILURE");
            $finish;
        end
    end

    t_row table_rows[$];

    task automatic add_row(input logic [1:0] op, input logic [31:0] v, input logic [31:0] m,
                           input bit fx, input logic [31:0] p, input logic [31:0] a);
        t_row r;
        r.op = op; r.val = v; r.macc = m; r.fixed = fx; r.pos_exp = p; r.acc_exp = a;
        table_rows.push_back(r);
    endtask

    task automatic random_word();
        int k;
        logic [1:0] op;
        logic [31:0] v, m;
        k = $urandom_range(99);
        op = k < 45 ? OP_MOVE : k < 90 ? OP_MEASURE : k < 97 ? OP_RELOAD : OP_UNUSED;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(2000000) - 1000000;
            2: v = {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            default: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        case ($urandom_range(3))
            0: m = $urandom;
            1: m = $urandom_range(1 << 20);
            2: m = 32'hFFFF_FFFF;
            default: m = $urandom_range(3);
        endcase
        send_word(op, v, m);
    endtask

    initial begin
        t_estimate e;
        est_pos  = 0;
        est_cov  = COV_RESET;
        cfg_pos  = 0;
        cfg_acc  = ACC_RESET;
        cfg_mult = MULT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: position 0, accuracy 2*sqrt(0.25 raw)=65536
        add_row(OP_UNUSED, 32'h0, 32'h0, 1, 32'h0, 32'd65536);
        add_row(OP_RELOAD, 32'h0, 32'h0, 1, 32'h0, 32'd65536);
        add_row(OP_MOVE, 32'h0, 32'h0, 1, 32'h0, 32'd65536);
        add_row(OP_MOVE, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
        add_row(OP_MOVE, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
        add_row(OP_MOVE, 32'h8000_0000, 32'h0, 0, 0, 0);
        add_row(OP_MOVE, 32'h8000_0000, 32'h0, 0, 0, 0);
        add_row(OP_MEASURE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(OP_MEASURE, 32'h8000_0000, 32'h0, 0, 0, 0);
        add_row(OP_MEASURE, 32'h0001_0000, 32'h1, 0, 0, 0);
        add_row(OP_MEASURE, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0);
        add_row(OP_MOVE, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
        add_row(OP_RELOAD, 32'h1234_5678, 32'h0, 1, 32'h0, 32'd65536);
        foreach (table_rows[i]) begin
            e = '{pos: est_pos[31:0], acc: 0};
            send_word(table_rows[i].op, table_rows[i].val, table_rows[i].macc);
            if (table_rows[i].fixed) begin
                e = pending_q[$];
                if (e.pos !== table_rows[i].pos_exp || e.acc !== table_rows[i].acc_exp)
                    report("table row", e.acc, table_rows[i].acc_exp);
            end
        end
        drain();

        // zero accuracy and multiplier: zero total variance on measurement
        write_reg(CFG_INIT_POS, 32'h8000_0000);
        write_reg(CFG_INIT_ACC, 32'h0);
        write_reg(CFG_MULT, 32'h0);
        send_word(OP_RELOAD, 0, 0);
        send_word(OP_MOVE, 32'h4000_0000, 0);
        send_word(OP_MEASURE, 32'h7FFF_FFFF, 0);
        drain();

        write_reg(CFG_INIT_POS, 32'h7FFF_FFFF);
        write_reg(CFG_INIT_ACC, 32'hFFFF_FFFF);
        write_reg(CFG_MULT, 32'hFFFF_FFFF);
        send_word(OP_RELOAD, 0, 0);
        send_word(OP_MOVE, 32'h8000_0000, 0);
        send_word(OP_MEASURE, 32'h0, 32'h1);
        drain();

        // long receiver hold while the sender keeps going
        long_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join_none
        repeat (4) random_word();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_INIT_POS, $urandom);
            write_reg(CFG_INIT_ACC, phase == 0 ? 32'd1 : $urandom);
            write_reg(CFG_MULT, phase == 1 ? 32'd1 : $urandom_range(32'hFF_FFFF));
            if (phase == 3) quiet = 1'b1;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                random_word();
                if (n == 100) begin
                    i_in_valid <= 1'b0;
                    while (pending_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
